/* sv/prt_pkg.sv */
package prt_pkg;

  localparam int PEERS = 32;
  localparam int IDX_W = $clog2(PEERS);
  localparam int SCORE_W = 16;
  localparam int AMT_W = 11;
  localparam int TIME_W = 32;
  localparam int CNT_W = 4;
  localparam int QDEPTH = 2;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_REWARD = 4'd1;
  localparam logic [3:0] OP_PENALIZE = 4'd2;
  localparam logic [3:0] OP_QUERY = 4'd3;
  localparam logic [3:0] OP_SEEN = 4'd4;
  localparam logic [3:0] OP_PING = 4'd5;
  localparam logic [3:0] OP_PONG = 4'd6;
  localparam logic [3:0] OP_TICK = 4'd7;
  localparam logic [3:0] OP_HEART = 4'd8;
  localparam logic [3:0] OP_SHARE = 4'd9;
  localparam logic [3:0] OP_EVICT = 4'd10;

  localparam logic [2:0] CFG_INIT = 3'd0;
  localparam logic [2:0] CFG_THR = 3'd1;
  localparam logic [2:0] CFG_IBP = 3'd2;
  localparam logic [2:0] CFG_RAPID = 3'd3;
  localparam logic [2:0] CFG_HB = 3'd4;
  localparam logic [2:0] CFG_STALE = 3'd5;

  localparam int SCORE_CAP = 200;
  localparam int UNBAN_MARGIN = 20;
  localparam int SHARE_MIN = 20;
  localparam int RAPID_COUNT = 3;
  localparam int COUNT_MAX = 15;

  typedef struct packed {
    logic [3:0] op;
    logic [IDX_W-1:0] peer;
    logic in_range;
    logic signed [AMT_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic banned;
    logic [CNT_W-1:0] count;
    logic [TIME_W-1:0] seen;
    logic [TIME_W-1:0] ping;
    logic pending;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic signed [SCORE_W-1:0] clamp(input logic signed [SCORE_W+1:0] v);
    logic signed [SCORE_W-1:0] r;
    if (v > (SCORE_W+2)'(SCORE_CAP)) r = SCORE_W'(SCORE_CAP);
    else if (v < -(SCORE_W+2)'(1 << (SCORE_W-1))) r = {1'b1, {(SCORE_W-1){1'b0}}};
    else r = v[SCORE_W-1:0];
    return r;
  endfunction

endpackage

/* sv/peer_reputation_table_top.sv */
// channel | handshake           | payload
// in      | start / busy        | in_operation, in_peer, in_amount
// out     | out_valid strobe    | out_peer_out, out_found, out_score_out, out_banned_flag,
//         |                     | out_just_banned, out_last_result
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
// point operations go through the back end as a ram read, then write and reply
// tick and unknown codes are handled in the idle state alone; scans do one ram read per
// entry (S_SCAN, then S_SCAN_EVAL), and add a flush state when the last entry matches
// a two-entry command queue lets start be taken while the back end works
// reset is synchronous and clears the valid bits and the seconds clock
// results cannot be stalled
module peer_reputation_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_operation,
  input  logic [4:0]         in_peer,
  input  logic signed [10:0] in_amount,
  output logic               out_valid,
  output logic [4:0]         out_peer_out,
  output logic               out_found,
  output logic signed [15:0] out_score_out,
  output logic               out_banned_flag,
  output logic               out_just_banned,
  output logic               out_last_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic q_valid, q_pop;
  prt_pkg::cmd_t q_cmd;
  logic signed [15:0] init_score, ban_thr;
  logic signed [10:0] ibp, rapid;
  logic [31:0] hb_to, stale_to;

  prt_cfg u_cfg (.*);

  prt_front u_front (.*);

  prt_back u_back (.*);
endmodule

/* sv/prt_ram.sv */
module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* sv/prt_front.sv */
module prt_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [3:0]                      in_operation,
  input  logic [4:0]                      in_peer,
  input  logic signed [10:0]              in_amount,
  output logic                            q_valid,
  output prt_pkg::cmd_t                   q_cmd,
  input  logic                            q_pop
);
  prt_pkg::cmd_t q_r [prt_pkg::QDEPTH];
  prt_pkg::cmd_t q0_nxt, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] slot;
  logic push;
  prt_pkg::cmd_t c;

  assign busy = (cnt_r == 2'(prt_pkg::QDEPTH));
  assign push = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[0];

  always_comb begin
    c.op = in_operation;
    c.peer = in_peer[prt_pkg::IDX_W-1:0];
    c.in_range = (32'(in_peer) < 32'(prt_pkg::PEERS));
    c.amount = in_amount;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
    slot = cnt_r - 2'(q_pop);
    q0_nxt = q_pop ? q_r[1] : q_r[0];
    q1_nxt = q_r[1];
    if (push) begin
      if (slot == 2'd0) q0_nxt = c;
      else q1_nxt = c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r[0] <= q0_nxt;
    q_r[1] <= q1_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(prt_pkg::QDEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) push && !q_pop |=> q_valid)
    else $error("push lost");
endmodule

/* sv/prt_back.sv */
module prt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  prt_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  input  logic signed [15:0]            init_score,
  input  logic signed [15:0]            ban_thr,
  input  logic signed [10:0]            ibp,
  input  logic signed [10:0]            rapid,
  input  logic [31:0]                   hb_to,
  input  logic [31:0]                   stale_to,
  output logic                          out_valid,
  output logic [4:0]                    out_peer_out,
  output logic                          out_found,
  output logic signed [15:0]            out_score_out,
  output logic                          out_banned_flag,
  output logic                          out_just_banned,
  output logic                          out_last_result
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_SCAN_EVAL, S_FLUSH} state_t;
  localparam int IW = prt_pkg::IDX_W;

  state_t state_r;
  prt_pkg::cmd_t cmd_r;
  logic [prt_pkg::PEERS-1:0] valid_r;
  logic [31:0] clock_r;
  logic [IW:0] idx_r;
  logic hold_r;
  logic [4:0] h_peer_r;
  logic signed [15:0] h_score_r;
  logic h_ban_r;

  logic we;
  logic [IW-1:0] raddr;
  prt_pkg::entry_t rd, wd;

  prt_ram #(.WIDTH(prt_pkg::ENTRY_W), .DEPTH(prt_pkg::PEERS)) u_ram (
    .clk(clk), .we(we), .waddr(cmd_r.peer), .wdata(wd), .raddr(raddr), .rdata(rd)
  );

  logic here, hit;
  logic signed [17:0] s1;
  logic signed [15:0] sc1, sc2;
  logic [3:0] cnt1;
  logic jb;
  logic [IW-1:0] sidx;
  logic [31:0] dping, dseen;

  assign sidx = idx_r[IW-1:0];
  assign raddr = (state_r == S_IDLE) ? q_cmd.peer : sidx;
  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign here = cmd_r.in_range && valid_r[cmd_r.peer];
  assign dping = clock_r - rd.ping;
  assign dseen = clock_r - rd.seen;

  always_comb begin
    s1 = 18'(rd.score) + 18'(cmd_r.amount);
    sc1 = prt_pkg::clamp(s1);
    cnt1 = rd.count;
    sc2 = sc1;
    if (cmd_r.amount == ibp) begin
      if (rd.count != 4'(prt_pkg::COUNT_MAX)) cnt1 = rd.count + 4'd1;
      if (cnt1 == 4'(prt_pkg::RAPID_COUNT)) sc2 = prt_pkg::clamp(18'(sc1) + 18'(rapid));
    end
    jb = (sc2 <= ban_thr);
    wd = rd;
    we = 1'b0;
    if (state_r == S_READ && here) begin
      unique case (cmd_r.op)
        prt_pkg::OP_REWARD: begin
          we = 1'b1;
          wd.score = sc1;
          if (rd.banned && 18'(sc1) > 18'(ban_thr) + 18'(prt_pkg::UNBAN_MARGIN)) begin
            wd.banned = 1'b0;
            wd.count = '0;
          end
        end
        prt_pkg::OP_PENALIZE: begin
          we = 1'b1;
          wd.score = sc2;
          wd.count = cnt1;
          if (jb) wd.banned = 1'b1;
        end
        prt_pkg::OP_SEEN: begin
          we = 1'b1;
          wd.seen = clock_r;
        end
        prt_pkg::OP_PING: begin
          we = !rd.pending;
          wd.ping = clock_r;
          wd.pending = 1'b1;
        end
        prt_pkg::OP_PONG: begin
          we = 1'b1;
          wd.pending = 1'b0;
          wd.seen = clock_r;
        end
        default: we = 1'b0;
      endcase
    end
    if (state_r == S_READ && cmd_r.op == prt_pkg::OP_ADD && cmd_r.in_range && !here) begin
      we = 1'b1;
      wd.score = init_score;
      wd.banned = 1'b0;
      wd.count = '0;
      wd.seen = clock_r;
      wd.ping = '0;
      wd.pending = 1'b0;
    end
    hit = 1'b0;
    if (valid_r[sidx]) begin
      case (cmd_r.op)
        prt_pkg::OP_HEART: hit = rd.pending && (dping > hb_to);
        prt_pkg::OP_SHARE: hit = !rd.banned && (rd.score > 16'(prt_pkg::SHARE_MIN));
        default: hit = dseen > stale_to;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      clock_r <= '0;
      out_valid <= 1'b0;
      hold_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            idx_r <= '0;
            hold_r <= 1'b0;
            if (q_cmd.op == prt_pkg::OP_TICK) begin
              clock_r <= clock_r + 32'd1;
            end else if (q_cmd.op == prt_pkg::OP_HEART || q_cmd.op == prt_pkg::OP_SHARE
                         || q_cmd.op == prt_pkg::OP_EVICT) begin
              state_r <= S_SCAN;
            end else if (q_cmd.op <= prt_pkg::OP_PONG) begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_IDLE;
          if (cmd_r.op == prt_pkg::OP_ADD && cmd_r.in_range && !here)
            valid_r[cmd_r.peer] <= 1'b1;
          if (cmd_r.op == prt_pkg::OP_PENALIZE || cmd_r.op == prt_pkg::OP_QUERY) begin
            out_valid <= 1'b1;
            out_peer_out <= 5'(cmd_r.peer);
            out_found <= here;
            out_last_result <= 1'b1;
            out_score_out <= '0;
            out_banned_flag <= 1'b0;
            out_just_banned <= 1'b0;
            if (here) begin
              if (cmd_r.op == prt_pkg::OP_PENALIZE) begin
                out_score_out <= sc2;
                out_banned_flag <= rd.banned | jb;
                out_just_banned <= jb;
              end else begin
                out_score_out <= rd.score;
                out_banned_flag <= rd.banned;
              end
            end
          end
        end
        S_SCAN: begin
          state_r <= S_SCAN_EVAL;
        end
        S_SCAN_EVAL: begin
          if (hit) begin
            if (hold_r) begin
              out_valid <= 1'b1;
              out_peer_out <= h_peer_r;
              out_found <= 1'b1;
              out_score_out <= h_score_r;
              out_banned_flag <= h_ban_r;
              out_just_banned <= 1'b0;
              out_last_result <= 1'b0;
            end
            hold_r <= 1'b1;
            h_peer_r <= 5'(sidx);
            h_score_r <= rd.score;
            h_ban_r <= rd.banned;
            if (cmd_r.op == prt_pkg::OP_EVICT) valid_r[sidx] <= 1'b0;
          end
          if (idx_r == (IW+1)'(prt_pkg::PEERS - 1)) begin
            if (hit) begin
              state_r <= S_FLUSH;
            end else begin
              state_r <= S_IDLE;
              if (hold_r) begin
                out_valid <= 1'b1;
                out_peer_out <= h_peer_r;
                out_found <= 1'b1;
                out_score_out <= h_score_r;
                out_banned_flag <= h_ban_r;
                out_just_banned <= 1'b0;
                out_last_result <= 1'b1;
              end
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_FLUSH: begin
          state_r <= S_IDLE;
          out_valid <= 1'b1;
          out_peer_out <= h_peer_r;
          out_found <= 1'b1;
          out_score_out <= h_score_r;
          out_banned_flag <= h_ban_r;
          out_just_banned <= 1'b0;
          out_last_result <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> state_r == S_IDLE)
    else $error("pop while working");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> state_r == S_SCAN_EVAL)
    else $error("scan sequence broken");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_IDLE)
    else $error("read did not finish");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |=> state_r == S_IDLE)
    else $error("flush did not finish");
endmodule

/* sv/prt_cfg.sv */
module prt_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic signed [15:0] init_score,
  output logic signed [15:0] ban_thr,
  output logic signed [10:0] ibp,
  output logic signed [10:0] rapid,
  output logic [31:0]        hb_to,
  output logic [31:0]        stale_to
);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_score <= 16'sd100;
      ban_thr <= -16'sd100;
      ibp <= -11'sd50;
      rapid <= -11'sd100;
      hb_to <= 32'd30;
      stale_to <= 32'd300;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        prt_pkg::CFG_INIT: init_score <= cfg_data[15:0];
        prt_pkg::CFG_THR: ban_thr <= cfg_data[15:0];
        prt_pkg::CFG_IBP: ibp <= cfg_data[10:0];
        prt_pkg::CFG_RAPID: rapid <= cfg_data[10:0];
        prt_pkg::CFG_HB: hb_to <= cfg_data;
        prt_pkg::CFG_STALE: stale_to <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam logic [3:0] OP_BAD_LO = 4'd11;
  localparam logic [3:0] OP_BAD_HI = 4'd15;

  typedef struct {
    logic [3:0]         op;
    logic [4:0]         peer;
    logic signed [10:0] amount;
  } cmd_item_t;

  typedef struct {
    logic [4:0]         peer;
    logic               found;
    logic signed [15:0] score;
    logic               banned;
    logic               jb;
    logic               last;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         in_operation = '0;
  logic [4:0]         in_peer = '0;
  logic signed [10:0] in_amount = '0;
  logic               out_valid;
  logic [4:0]         out_peer_out;
  logic               out_found;
  logic signed [15:0] out_score_out;
  logic               out_banned_flag;
  logic               out_just_banned;
  logic               out_last_result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  peer_reputation_table_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // reputation model state
  logic               pv_valid [prt_pkg::PEERS];
  int                 pv_score [prt_pkg::PEERS];
  logic               pv_ban [prt_pkg::PEERS];
  int                 pv_cnt [prt_pkg::PEERS];
  logic [31:0]        pv_seen [prt_pkg::PEERS];
  logic [31:0]        pv_ping [prt_pkg::PEERS];
  logic               pv_pend [prt_pkg::PEERS];
  logic [31:0]        now_s;
  logic signed [15:0] c_init, c_thr;
  logic signed [10:0] c_ibp, c_rapid;
  logic [31:0]        c_hb, c_stale;

  cmd_item_t cmd_q[$];
  reply_t    reply_q[$];
  int        n_sent = 0, n_acc = 0, gap = 0, errors = 0;
  bit        calm = 0;

  function automatic int sat(int v);
    if (v > prt_pkg::SCORE_CAP) return prt_pkg::SCORE_CAP;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic push_reply(int p, logic f, int s, logic b, logic j, logic l);
    reply_t r;
    r.peer = p[4:0]; r.found = f; r.score = s[15:0]; r.banned = b; r.jb = j; r.last = l;
    reply_q = {reply_q, r};
  endtask

  task automatic apply_cmd(cmd_item_t c);
    int  p, a, hits;
    logic here, hit, j;
    int  hit_idx[$];
    p = c.peer;
    a = c.amount;
    here = pv_valid[p];
    case (c.op) inside
      prt_pkg::OP_ADD: if (!here) begin
        pv_valid[p] = 1; pv_score[p] = c_init; pv_ban[p] = 0; pv_cnt[p] = 0;
        pv_seen[p] = now_s; pv_ping[p] = 0; pv_pend[p] = 0;
      end
      prt_pkg::OP_REWARD: if (here) begin
        pv_score[p] = sat(pv_score[p] + a);
        if (pv_ban[p] && pv_score[p] > int'(c_thr) + prt_pkg::UNBAN_MARGIN) begin
          pv_ban[p] = 0; pv_cnt[p] = 0;
        end
      end
      prt_pkg::OP_PENALIZE: if (!here) push_reply(p, 0, 0, 0, 0, 1);
      else begin
        pv_score[p] = sat(pv_score[p] + a);
        if (c.amount == c_ibp) begin
          if (pv_cnt[p] < prt_pkg::COUNT_MAX) pv_cnt[p]++;
          if (pv_cnt[p] == prt_pkg::RAPID_COUNT)
            pv_score[p] = sat(pv_score[p] + int'(c_rapid));
        end
        j = pv_score[p] <= int'(c_thr);
        if (j) pv_ban[p] = 1;
        push_reply(p, 1, pv_score[p], pv_ban[p], j, 1);
      end
      prt_pkg::OP_QUERY: if (here) push_reply(p, 1, pv_score[p], pv_ban[p], 0, 1);
      else push_reply(p, 0, 0, 0, 0, 1);
      prt_pkg::OP_SEEN: if (here) pv_seen[p] = now_s;
      prt_pkg::OP_PING: if (here && !pv_pend[p]) begin
        pv_ping[p] = now_s; pv_pend[p] = 1;
      end
      prt_pkg::OP_PONG: if (here) begin
        pv_pend[p] = 0; pv_seen[p] = now_s;
      end
      prt_pkg::OP_TICK: now_s = now_s + 32'd1;
      prt_pkg::OP_HEART, prt_pkg::OP_SHARE, prt_pkg::OP_EVICT: begin
        for (int i = 0; i < prt_pkg::PEERS; i++) begin
          if (!pv_valid[i]) continue;
          if (c.op == prt_pkg::OP_HEART) hit = pv_pend[i] && (now_s - pv_ping[i]) > c_hb;
          else if (c.op == prt_pkg::OP_SHARE)
            hit = !pv_ban[i] && pv_score[i] > prt_pkg::SHARE_MIN;
          else hit = (now_s - pv_seen[i]) > c_stale;
          if (hit) hit_idx = {hit_idx, i};
        end
        hits = hit_idx.size();
        for (int k = 0; k < hits; k++) begin
          push_reply(hit_idx[k], 1, pv_score[hit_idx[k]], pv_ban[hit_idx[k]], 0, k == hits - 1);
          if (c.op == prt_pkg::OP_EVICT) pv_valid[hit_idx[k]] = 0;
        end
      end
      default: ;
    endcase
  endtask

  // command driver
  always @(negedge clk) begin
    cmd_item_t c;
    if (rst_n) begin
      if (start && n_acc != n_sent) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        in_operation <= c.op;
        in_peer <= c.peer;
        in_amount <= c.amount;
        start <= 1'b1;
        n_sent <= n_sent + 1;
        if (!calm && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 6);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // transfer acceptance and prediction
  always @(posedge clk) begin
    cmd_item_t c;
    if (rst_n && start && !busy) begin
      c.op = in_operation; c.peer = in_peer; c.amount = in_amount;
      apply_cmd(c);
      n_acc <= n_acc + 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result peer %0d score %0d", out_peer_out,
                                   out_score_out);
      end else begin
        e = reply_q.pop_front();
        if (out_peer_out !== e.peer || out_found !== e.found || out_score_out !== e.score ||
            out_banned_flag !== e.banned || out_just_banned !== e.jb ||
            out_last_result !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp p%0d f%0d s%0d b%0d j%0d l%0d got p%0d f%0d s%0d b%0d j%0d l%0d",
                     e.peer, e.found, e.score, e.banned, e.jb, e.last, out_peer_out,
                     out_found, out_score_out, out_banned_flag, out_just_banned,
                     out_last_result);
        end
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      prt_pkg::CFG_INIT:  c_init = val[15:0];
      prt_pkg::CFG_THR:   c_thr = val[15:0];
      prt_pkg::CFG_IBP:   c_ibp = val[10:0];
      prt_pkg::CFG_RAPID: c_rapid = val[10:0];
      prt_pkg::CFG_HB:    c_hb = val;
      prt_pkg::CFG_STALE: c_stale = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cfg_all(logic [31:0] i0, logic [31:0] th, logic [31:0] ib,
                         logic [31:0] rp, logic [31:0] hb, logic [31:0] st);
    cfg_write(prt_pkg::CFG_INIT, i0);
    cfg_write(prt_pkg::CFG_THR, th);
    cfg_write(prt_pkg::CFG_IBP, ib);
    cfg_write(prt_pkg::CFG_RAPID, rp);
    cfg_write(prt_pkg::CFG_HB, hb);
    cfg_write(prt_pkg::CFG_STALE, st);
  endtask

  task automatic put(logic [3:0] op, int p, int a);
    cmd_item_t c;
    c.op = op; c.peer = p[4:0]; c.amount = a[10:0];
    cmd_q = {cmd_q, c};
  endtask

  task automatic drain;
    while (cmd_q.size() > 0 || n_acc != n_sent || start || reply_q.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_cmds(int n);
    int r, p, a;
    logic [3:0] op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 12) op = prt_pkg::OP_ADD;
      else if (r < 22) op = prt_pkg::OP_REWARD;
      else if (r < 36) op = prt_pkg::OP_PENALIZE;
      else if (r < 48) op = prt_pkg::OP_QUERY;
      else if (r < 54) op = prt_pkg::OP_SEEN;
      else if (r < 62) op = prt_pkg::OP_PING;
      else if (r < 68) op = prt_pkg::OP_PONG;
      else if (r < 82) op = prt_pkg::OP_TICK;
      else if (r < 86) op = prt_pkg::OP_HEART;
      else if (r < 90) op = prt_pkg::OP_SHARE;
      else if (r < 94) op = prt_pkg::OP_EVICT;
      else op = 4'($urandom_range(int'(OP_BAD_LO), int'(OP_BAD_HI)));
      p = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
      a = $signed(11'($urandom));
      if (op == prt_pkg::OP_PENALIZE && $urandom_range(0, 2) == 0) a = c_ibp;
      put(op, p, a);
    end
  endtask

  initial begin
    for (int i = 0; i < prt_pkg::PEERS; i++) begin
      pv_valid[i] = 0; pv_score[i] = 0; pv_ban[i] = 0; pv_cnt[i] = 0;
      pv_seen[i] = 0; pv_ping[i] = 0; pv_pend[i] = 0;
    end
    now_s = 0;
    c_init = 100; c_thr = -100; c_ibp = -50; c_rapid = -100; c_hb = 30; c_stale = 300;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: absent entries, caps, floor, rapid misbehavior, scans, unknown codes
    put(prt_pkg::OP_QUERY, 31, 0);
    put(prt_pkg::OP_PENALIZE, 30, -5);
    put(prt_pkg::OP_ADD, 0, 0);
    put(prt_pkg::OP_ADD, 1, 0);
    put(prt_pkg::OP_REWARD, 0, 1023);
    put(prt_pkg::OP_QUERY, 0, 0);
    put(prt_pkg::OP_PENALIZE, 1, -50);
    put(prt_pkg::OP_PENALIZE, 1, -50);
    put(prt_pkg::OP_PENALIZE, 1, -50);
    put(prt_pkg::OP_PENALIZE, 1, -1024);
    put(prt_pkg::OP_REWARD, 1, 1023);
    put(prt_pkg::OP_QUERY, 1, 0);
    put(prt_pkg::OP_PING, 0, 0);
    put(prt_pkg::OP_SHARE, 0, 0);
    put(prt_pkg::OP_HEART, 0, 0);
    put(prt_pkg::OP_EVICT, 0, 0);
    put(prt_pkg::OP_TICK, 0, 0);
    put(prt_pkg::OP_PONG, 0, 0);
    put(prt_pkg::OP_SEEN, 1, 0);
    put(OP_BAD_LO, 2, 0);
    put(OP_BAD_HI, 31, -1);
    put(prt_pkg::OP_REWARD, 5, 7);
    drain();

    cfg_all(200, -32768, -1024, 0, 0, 0);
    for (int i = 0; i < 20; i++) put(prt_pkg::OP_PENALIZE, 2, -1024);
    put(prt_pkg::OP_ADD, 2, 0);
    for (int i = 0; i < 34; i++) put(prt_pkg::OP_PENALIZE, 2, -1024);
    put(prt_pkg::OP_PING, 2, 0);
    put(prt_pkg::OP_TICK, 0, 0);
    put(prt_pkg::OP_HEART, 0, 0);
    put(prt_pkg::OP_EVICT, 0, 0);
    random_cmds(60);
    drain();

    cfg_all(-32768, 200, 0, -1024, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_cmds(80);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      cfg_all($urandom_range(0, 400) - 200, $urandom_range(0, 300) - 200,
              -$urandom_range(0, 1024), -$urandom_range(0, 1024),
              $urandom_range(0, 8), $urandom_range(2, 20));
      if (ph == 2) calm = 1;
      random_cmds(90);
      drain();
    end

    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
